// ===== hw/rtl/ufpe_pkg.sv =====
// Package for the form-urlencoding percent encoder.
// Holds widths, encoding-class codes, character constants and the character
// lookup functions shared by the decode and emit stages. No dependencies.
package ufpe_pkg;

   localparam int CHAR_W         = 8;
   localparam int LEN_W          = 16;
   localparam int COUNT_BITS_DEF = 16;
   localparam int IDX_W          = 3;

   // Encoding class of one input byte.
   localparam logic [1:0] KIND_PASS = 2'd0;
   localparam logic [1:0] KIND_PLUS = 2'd1;
   localparam logic [1:0] KIND_HEX  = 2'd2;
   localparam logic [1:0] KIND_CRLF = 2'd3;

   localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
   localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UP_A    = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UP_D    = 8'h44;
   localparam logic [CHAR_W-1:0] CH_UP_Z    = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_LO_A    = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LO_Z    = 8'h7A;
   localparam logic [CHAR_W-1:0] CH_DASH    = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_UNDER   = 8'h5F;
   localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_TILDE   = 8'h7E;

   // Held item between the decode stage and the emitter.
   typedef struct packed {
      logic              valid;
      logic [1:0]        kind;
      logic [CHAR_W-1:0] data;
      logic              last;
   } item_type;

   function automatic logic passes_through(input logic [CHAR_W-1:0] b);
      passes_through = (b >= CH_UP_A && b <= CH_UP_Z) ||
                       (b >= CH_LO_A && b <= CH_LO_Z) ||
                       (b >= CH_ZERO && b <= CH_NINE) ||
                       b == CH_DASH || b == CH_UNDER || b == CH_DOT || b == CH_TILDE;
   endfunction

   function automatic logic [CHAR_W-1:0] hex_digit(input logic [3:0] nib);
      if (nib < 4'd10) begin
         hex_digit = CH_ZERO + {4'd0, nib};
      end else begin
         hex_digit = CH_UP_A + {4'd0, nib - 4'd10};
      end
   endfunction

   // Index of the final character of each class.
   function automatic logic [IDX_W-1:0] final_index(input logic [1:0] kind);
      case (kind)
         KIND_PASS: final_index = 3'd0;
         KIND_PLUS: final_index = 3'd0;
         KIND_HEX:  final_index = 3'd2;
         KIND_CRLF: final_index = 3'd5;
         default:   final_index = 3'd0;
      endcase
   endfunction

   function automatic logic [CHAR_W-1:0] char_at(input logic [1:0]        kind,
                                                 input logic [CHAR_W-1:0] data,
                                                 input logic [IDX_W-1:0]  idx);
      case (kind)
         KIND_PASS: char_at = data;
         KIND_PLUS: char_at = CH_PLUS;
         KIND_HEX: begin
            case (idx)
               3'd0:    char_at = CH_PERCENT;
               3'd1:    char_at = hex_digit(data[7:4]);
               default: char_at = hex_digit(data[3:0]);
            endcase
         end
         KIND_CRLF: begin
            case (idx)
               3'd0, 3'd3: char_at = CH_PERCENT;
               3'd1, 3'd4: char_at = CH_ZERO;
               3'd2:       char_at = CH_UP_D;
               default:    char_at = CH_UP_A;
            endcase
         end
         default: char_at = data;
      endcase
   endfunction

endpackage

// ===== hw/rtl/ufpe_ifs.sv =====
// Request and response channel interfaces of the percent encoder.
// Depends on ufpe_pkg for the field widths.
interface ufpe_req_if import ufpe_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] in_char;
   logic              in_last;

   modport source(output valid, output in_char, output in_last, input ready);
   modport sink(input valid, input in_char, input in_last, output ready);
endinterface

interface ufpe_rsp_if import ufpe_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] out_char;
   logic              run_last;
   logic              fragment_done;
   logic [LEN_W-1:0]  encoded_length;

   modport source(output valid, output out_char, output run_last,
                  output fragment_done, output encoded_length, input ready);
   modport sink(input valid, input out_char, input run_last,
                input fragment_done, input encoded_length, output ready);
endinterface

// ===== hw/rtl/ufpe_decode.sv =====
// Input stage of the percent encoder: classifies each accepted byte and
// holds it until the emitter has taken its last character. Uses ufpe_pkg.
module ufpe_decode import ufpe_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CHAR_W-1:0] req_char,
   input  logic              req_last,
   output item_type          item,
   input  logic              item_take
);

   item_type          item_ff, item_in;
   logic [CHAR_W-1:0] prev_byte_ff, prev_byte_in;
   logic [1:0]        kind;
   logic              accept;

   assign req_ready = !item_ff.valid || item_take;
   assign accept    = req_valid && req_ready;
   assign item      = item_ff;

   always_comb begin
      if (req_char == CH_LF && prev_byte_ff != CH_CR) begin
         kind = KIND_CRLF;
      end else if (req_char == CH_SPACE) begin
         kind = KIND_PLUS;
      end else if (passes_through(req_char)) begin
         kind = KIND_PASS;
      end else begin
         kind = KIND_HEX;
      end
   end

   always_comb begin
      item_in      = item_ff;
      prev_byte_in = prev_byte_ff;
      if (item_take) begin
         item_in.valid = 1'b0;
      end
      if (accept) begin
         item_in.valid = 1'b1;
         item_in.kind  = kind;
         item_in.data  = req_char;
         item_in.last  = req_last;
         // The carriage-return memory spans only one fragment.
         prev_byte_in  = req_last ? '0 : req_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
         prev_byte_ff  <= '0;
      end else begin
         item_ff.valid <= item_in.valid;
         prev_byte_ff  <= prev_byte_in;
      end
      item_ff.kind <= item_in.kind;
      item_ff.data <= item_in.data;
      item_ff.last <= item_in.last;
   end

endmodule

// ===== hw/rtl/ufpe_emit.sv =====
// Character emitter of the percent encoder: walks the held item one character
// per cycle, unless the response register is stalled, into that register and
// keeps the saturating count. Uses ufpe_pkg.
module ufpe_emit import ufpe_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  item_type          item,
   output logic              item_take,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CHAR_W-1:0] rsp_char,
   output logic              rsp_run_last,
   output logic              rsp_done,
   output logic [LEN_W-1:0]  rsp_length
);

   localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic [COUNT_BITS-1:0]         count_ff, count_in;
   logic [COUNT_BITS-1:0]         count_sat;
   logic [COUNT_BITS+LEN_W-1:0]   count_wide;
   logic                          out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]             out_char_ff, out_char_in;
   logic                          run_last_ff, run_last_in;
   logic                          done_ff, done_in;
   logic [LEN_W-1:0]              length_ff, length_in;
   logic                          load;
   logic                          is_final;

   assign load      = item.valid && (!out_valid_ff || rsp_ready);
   assign is_final  = idx_ff == final_index(item.kind);
   assign item_take = load && is_final;
   assign count_sat = (count_ff == CountMax) ? count_ff : count_ff + 1'b1;
   assign count_wide = {{LEN_W{1'b0}}, count_sat};

   always_comb begin
      idx_in       = idx_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_char_in  = out_char_ff;
      run_last_in  = run_last_ff;
      done_in      = done_ff;
      length_in    = length_ff;
      if (load) begin
         out_valid_in = 1'b1;
         out_char_in  = char_at(item.kind, item.data, idx_ff);
         run_last_in  = is_final;
         done_in      = is_final && item.last;
         length_in    = count_wide[LEN_W-1:0];
         idx_in       = is_final ? '0 : idx_ff + 1'b1;
         count_in     = (is_final && item.last) ? '0 : count_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
      out_char_ff <= out_char_in;
      run_last_ff <= run_last_in;
      done_ff     <= done_in;
      length_ff   <= length_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_char     = out_char_ff;
   assign rsp_run_last = run_last_ff;
   assign rsp_done     = done_ff;
   assign rsp_length   = length_ff;

endmodule

// ===== hw/rtl/url_form_percent_encoder_unit.sv =====
// Form-urlencoding percent encoder, top level. Depends on ufpe_pkg,
// ufpe_ifs, ufpe_decode and ufpe_emit.
// Each byte passes the decode item register and then the response register.
// Throughput: one byte per cycle for pass-through and space, while responses are
// taken; a hex or CR LF escape holds the input until its final character is taken,
// set by the single response register that takes one character per cycle.
// Reset clears the valid flags, the character index, the count and the last byte.
module url_form_percent_encoder_unit import ufpe_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   ufpe_req_if.sink   req_bus,
   ufpe_rsp_if.source rsp_bus
);

   item_type item;
   logic     item_take;

   ufpe_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .req_char  (req_bus.in_char),
      .req_last  (req_bus.in_last),
      .item      (item),
      .item_take (item_take)
   );

   ufpe_emit #(
      .COUNT_BITS (COUNT_BITS)
   ) u_emit (
      .clock        (clock),
      .reset        (reset),
      .item         (item),
      .item_take    (item_take),
      .rsp_valid    (rsp_bus.valid),
      .rsp_ready    (rsp_bus.ready),
      .rsp_char     (rsp_bus.out_char),
      .rsp_run_last (rsp_bus.run_last),
      .rsp_done     (rsp_bus.fragment_done),
      .rsp_length   (rsp_bus.encoded_length)
   );

endmodule
